FILE: rtl/afdp_pkg.sv
// afdp_pkg: shared types and constants for the audio format descriptor parser
// beat payload structs, function codes, walk phases and controller states
// no dependencies
package afdp_pkg;

    localparam int MAX_RATES_DEF = 8;

    localparam logic [7:0] HDR_LEN        = 8'd8;
    localparam logic [7:0] DESC_TYPE_CS   = 8'h24;
    localparam logic [7:0] SUBTYPE_FORMAT = 8'h02;
    localparam logic [7:0] FORMAT_TYPE_I  = 8'h01;

    localparam logic [7:0] OFF_TYPE    = 8'd1;
    localparam logic [7:0] OFF_SUBTYPE = 8'd2;
    localparam logic [7:0] OFF_FORMAT  = 8'd3;
    localparam logic [7:0] OFF_CHAN    = 8'd4;
    localparam logic [7:0] OFF_SUB     = 8'd5;
    localparam logic [7:0] OFF_RES     = 8'd6;
    localparam logic [7:0] OFF_COUNT   = 8'd7;

    localparam logic [2:0] MATCH_ALL = 3'b111;

    typedef enum logic [1:0] {
        FUNC_BYTE  = 2'd0,
        FUNC_RATE  = 2'd1,
        FUNC_PSIZE = 2'd2,
        FUNC_NONE  = 2'd3
    } afdp_func_t;

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_OK,
        PH_FAIL
    } afdp_phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FAIL,
        ST_EMIT_RD,
        ST_EMIT_OUT,
        ST_QRY_RD,
        ST_QRY_CMP,
        ST_QRY_OUT,
        ST_MUL1,
        ST_MUL2,
        ST_MUL_OUT
    } afdp_state_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [23:0] query_rate;
        logic [15:0] sample_count;
    } afdp_item_t;

    typedef struct packed {
        logic        status;
        logic [7:0]  channel_count;
        logic [7:0]  subframe_bytes;
        logic [7:0]  resolution_bits;
        logic [3:0]  rate_total;
        logic [2:0]  rate_index;
        logic [23:0] rate_hz;
        logic        rate_supported;
        logic [31:0] packet_size;
        logic        last_result;
    } afdp_result_t;

endpackage

FILE: rtl/audio_format_descriptor_parser_top.sv
// audio_format_descriptor_parser_top: type I format descriptor walker with queries
// rate lists live in one two-bank memory, staging and kept banks swap on commit
// depends on afdp_pkg
//
// usage
// - item channel (item_valid/item_ready/item): func 0 carries one descriptor byte,
//   func 1 a rate support query, func 2 a packet size query, func 3 is dropped
// - result channel (result_valid/result_ready/result): one output register
// - a descriptor byte that is not the last one gives no beat
// - the last byte gives one failure beat, or one beat per kept rate, each rate
//   read from the rate memory in ST_EMIT_RD and given out in ST_EMIT_OUT
// - a rate query scans the kept rates through ST_QRY_RD and ST_QRY_CMP, then gives one beat
// - a packet size query goes through two chained multiplies, ST_MUL1 and ST_MUL2
// - one item is worked at a time; item_ready is high only while the controller
//   is idle, and a finished beat may wait in the output register meanwhile
// - with a beat held and result_ready low, the controller holds its pending beat
// - reset clears the walk, the kept format and the rate count; no memory clearing
module audio_format_descriptor_parser_top #(
    parameter int MAX_RATES = afdp_pkg::MAX_RATES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  afdp_pkg::afdp_item_t  item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output afdp_pkg::afdp_result_t result
);
    import afdp_pkg::*;

    localparam int CW = $clog2(MAX_RATES + 1);
    localparam int AW = (MAX_RATES > 1) ? $clog2(MAX_RATES) : 1;
    localparam int DEPTH = 2 * (1 << AW);

    // rate memory, bank bit on top
    logic [23:0]   rate_mem [DEPTH];
    logic          wr_en;
    logic [AW:0]   wr_addr;
    logic [23:0]   wr_data;
    logic          rd_en;
    logic [AW:0]   rd_addr;
    logic [23:0]   rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rate_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= rate_mem[rd_addr];
        end
    end

    // walk state
    logic [7:0]    off_reg, off_next;
    logic [7:0]    len_reg, len_next;
    afdp_phase_t   phase_reg, phase_next, phase_walk;
    logic [2:0]    match_reg, match_next;
    logic [7:0]    stg_ch_reg, stg_ch_next;
    logic [7:0]    stg_sub_reg, stg_sub_next;
    logic [7:0]    stg_res_reg, stg_res_next;
    logic [CW-1:0] stg_cnt_reg, stg_cnt_next;
    logic [CW-1:0] ridx_reg, ridx_next;
    logic [1:0]    bpos_reg, bpos_next;
    logic [15:0]   acc_reg, acc_next;
    logic [7:0]    kept_ch_reg, kept_ch_next;
    logic [7:0]    kept_sub_reg, kept_sub_next;
    logic [7:0]    kept_res_reg, kept_res_next;
    logic [CW-1:0] kept_cnt_reg, kept_cnt_next;
    logic          bank_reg, bank_next;

    // controller state
    afdp_state_t   state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          sup_reg, sup_next;
    logic [23:0]   qrate_reg, qrate_next;
    logic [15:0]   samples_reg, samples_next;
    logic [23:0]   prod_reg, prod_next;
    logic [31:0]   psize_reg, psize_next;
    logic          result_valid_reg, result_valid_next;
    afdp_result_t  result_reg, result_next;

    logic          accept;
    logic          walk_en;
    logic          slot_free;
    logic          out_load;
    afdp_result_t  res;
    logic [CW-1:0] cnt_inc;
    logic [CW+3:0] total_wide;
    logic [CW+2:0] index_wide;

    assign accept    = item_valid && item_ready;
    assign walk_en   = accept && (item.func == FUNC_BYTE) && (phase_reg == PH_SEARCH);
    assign slot_free = !result_valid_reg || result_ready;
    assign cnt_inc   = CW'(cnt_reg + 1'b1);

    // byte walk
    always_comb
    begin
        logic [7:0] b;
        logic [2:0] m;
        logic       matching;
        logic [9:0] need_len;
        b          = item.data_byte;
        off_next   = off_reg;
        len_next   = len_reg;
        phase_walk = phase_reg;
        match_next = match_reg;
        stg_ch_next  = stg_ch_reg;
        stg_sub_next = stg_sub_reg;
        stg_res_next = stg_res_reg;
        stg_cnt_next = stg_cnt_reg;
        ridx_next    = ridx_reg;
        bpos_next    = bpos_reg;
        acc_next     = acc_reg;
        kept_ch_next  = kept_ch_reg;
        kept_sub_next = kept_sub_reg;
        kept_res_next = kept_res_reg;
        kept_cnt_next = kept_cnt_reg;
        bank_next     = bank_reg;
        wr_en   = 1'b0;
        wr_addr = {~bank_reg, ridx_reg[AW-1:0]};
        wr_data = {b, acc_reg};
        m        = match_reg;
        matching = 1'b0;
        need_len = 10'(HDR_LEN) + 10'(b) * 10'd3;

        if (walk_en)
        begin
            if (off_reg == 8'd0)
            begin
                if (b < 8'd2)
                begin
                    phase_walk = PH_FAIL;
                end
                else
                begin
                    len_next   = b;
                    match_next = 3'b000;
                    off_next   = 8'd1;
                end
            end
            else
            begin
                if (off_reg == OFF_TYPE && b == DESC_TYPE_CS)
                begin
                    m[0] = 1'b1;
                end
                if (off_reg == OFF_SUBTYPE && b == SUBTYPE_FORMAT)
                begin
                    m[1] = 1'b1;
                end
                if (off_reg == OFF_FORMAT && b == FORMAT_TYPE_I)
                begin
                    m[2] = 1'b1;
                end
                match_next = m;
                if (off_reg == OFF_CHAN)
                begin
                    stg_ch_next = b;
                end
                if (off_reg == OFF_SUB)
                begin
                    stg_sub_next = b;
                end
                if (off_reg == OFF_RES)
                begin
                    stg_res_next = b;
                end
                matching = (len_reg >= HDR_LEN) && (m == MATCH_ALL);

                if (matching && off_reg == OFF_COUNT &&
                    (b == 8'd0 || 9'(b) > 9'(MAX_RATES) || 10'(len_reg) < need_len))
                begin
                    phase_walk = PH_FAIL;
                end
                else
                begin
                    if (matching && off_reg == OFF_COUNT)
                    begin
                        stg_cnt_next = CW'(b);
                        ridx_next    = '0;
                        bpos_next    = 2'd0;
                    end
                    else if (matching && off_reg > OFF_COUNT)
                    begin
                        bpos_next = (bpos_reg == 2'd2) ? 2'd0 : 2'(bpos_reg + 1'b1);
                        if (ridx_reg < stg_cnt_reg)
                        begin
                            case (bpos_reg)
                                2'd0:
                                begin
                                    acc_next[7:0] = b;
                                end
                                2'd1:
                                begin
                                    acc_next[15:8] = b;
                                end
                                default:
                                begin
                                    wr_en     = 1'b1;
                                    ridx_next = CW'(ridx_reg + 1'b1);
                                end
                            endcase
                        end
                    end

                    if (9'(off_reg) + 9'd1 >= 9'(len_reg))
                    begin
                        if (matching)
                        begin
                            kept_ch_next  = stg_ch_next;
                            kept_sub_next = stg_sub_next;
                            kept_res_next = stg_res_next;
                            kept_cnt_next = stg_cnt_next;
                            bank_next     = ~bank_reg;
                            phase_walk    = PH_OK;
                        end
                        off_next = 8'd0;
                    end
                    else
                    begin
                        off_next = 8'(off_reg + 1'b1);
                    end
                end
            end
        end

        phase_next = phase_walk;
        if (accept && item.func == FUNC_BYTE && item.last_byte)
        begin
            off_next   = 8'd0;
            len_next   = 8'd0;
            match_next = 3'b000;
            phase_next = PH_SEARCH;
        end
    end

    // controller
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        sup_next     = sup_reg;
        qrate_next   = qrate_reg;
        samples_next = samples_reg;
        prod_next    = prod_reg;
        psize_next   = psize_reg;
        item_ready   = (state_reg == ST_IDLE);
        rd_en        = 1'b0;
        rd_addr      = {bank_reg, cnt_reg[AW-1:0]};
        out_load     = 1'b0;
        total_wide   = {4'b0, kept_cnt_reg};
        index_wide   = {3'b0, cnt_reg};

        res.status          = 1'b0;
        res.channel_count   = kept_ch_reg;
        res.subframe_bytes  = kept_sub_reg;
        res.resolution_bits = kept_res_reg;
        res.rate_total      = total_wide[3:0];
        res.rate_index      = 3'd0;
        res.rate_hz         = 24'd0;
        res.rate_supported  = 1'b0;
        res.packet_size     = 32'd0;
        res.last_result     = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    qrate_next   = item.query_rate;
                    samples_next = item.sample_count;
                    cnt_next     = '0;
                    sup_next     = 1'b0;
                    case (item.func)
                        FUNC_BYTE:
                        begin
                            if (item.last_byte)
                            begin
                                state_next = (phase_walk == PH_OK) ? ST_EMIT_RD : ST_FAIL;
                            end
                        end
                        FUNC_RATE:
                        begin
                            state_next = (kept_cnt_reg == '0) ? ST_QRY_OUT : ST_QRY_RD;
                        end
                        FUNC_PSIZE:
                        begin
                            state_next = ST_MUL1;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FAIL:
            begin
                res.status = 1'b1;
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                res.rate_index  = index_wide[2:0];
                res.rate_hz     = rd_data_reg;
                res.last_result = (cnt_inc == kept_cnt_reg);
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    cnt_next   = cnt_inc;
                    state_next = (cnt_inc == kept_cnt_reg) ? ST_IDLE : ST_EMIT_RD;
                end
            end
            ST_QRY_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_QRY_CMP;
            end
            ST_QRY_CMP:
            begin
                if (rd_data_reg == qrate_reg)
                begin
                    sup_next = 1'b1;
                end
                cnt_next   = cnt_inc;
                state_next = (cnt_inc == kept_cnt_reg) ? ST_QRY_OUT : ST_QRY_RD;
            end
            ST_QRY_OUT:
            begin
                res.rate_supported = sup_reg;
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_MUL1:
            begin
                prod_next  = 24'(samples_reg * kept_ch_reg);
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                psize_next = 32'(prod_reg * kept_sub_reg);
                state_next = ST_MUL_OUT;
            end
            ST_MUL_OUT:
            begin
                res.packet_size = psize_reg;
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        result_next       = out_load ? res : result_reg;
        result_valid_next = out_load ? 1'b1 : (result_ready ? 1'b0 : result_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg          <= 8'd0;
            len_reg          <= 8'd0;
            phase_reg        <= PH_SEARCH;
            match_reg        <= 3'b000;
            kept_ch_reg      <= 8'd0;
            kept_sub_reg     <= 8'd0;
            kept_res_reg     <= 8'd0;
            kept_cnt_reg     <= '0;
            bank_reg         <= 1'b0;
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            sup_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            off_reg          <= off_next;
            len_reg          <= len_next;
            phase_reg        <= phase_next;
            match_reg        <= match_next;
            kept_ch_reg      <= kept_ch_next;
            kept_sub_reg     <= kept_sub_next;
            kept_res_reg     <= kept_res_next;
            kept_cnt_reg     <= kept_cnt_next;
            bank_reg         <= bank_next;
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            sup_reg          <= sup_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stg_ch_reg  <= stg_ch_next;
        stg_sub_reg <= stg_sub_next;
        stg_res_reg <= stg_res_next;
        stg_cnt_reg <= stg_cnt_next;
        ridx_reg    <= ridx_next;
        bpos_reg    <= bpos_next;
        acc_reg     <= acc_next;
        qrate_reg   <= qrate_next;
        samples_reg <= samples_next;
        prod_reg    <= prod_next;
        psize_reg   <= psize_next;
        result_reg  <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // checks
    a_kept_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(kept_cnt_reg) <= MAX_RATES)
        else $error("kept rate count above limit");

    a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT_RD || state_reg == ST_EMIT_OUT) |-> cnt_reg < kept_cnt_reg)
        else $error("rate emit index past kept count");

    a_fail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status) |-> result.last_result)
        else $error("failure beat not marked last");

    a_walk_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.func == FUNC_BYTE && item.last_byte)
        |=> (off_reg == 8'd0 && phase_reg == PH_SEARCH))
        else $error("walk not restarted after last byte");

endmodule
